[rtl/keyword_substitution_cipher_top_defines.svh]
// Assertion macros for the keyword substitution cipher block.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_TOP_DEFINES_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while arst_n is low
`define KCS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kcs check failed");

// next-cycle implication
`define KCS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kcs check failed");

`else

`define KCS_ASSERT_NOW(lbl, ante, cons)
`define KCS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/kcs_pkg.sv]
// Shared constants, types and microcode ROM for the substitution cipher.
package kcs_pkg;

	// alphabet geometry
	localparam int ALPHABET_SIZE = 26;
	localparam int LW = $clog2(ALPHABET_SIZE);
	localparam int CW = $clog2(ALPHABET_SIZE + 1);
	localparam logic [7:0] LETTER_A = 8'h61;

	// item kinds
	localparam logic [1:0] KIND_CLEAR = 2'd0;
	localparam logic [1:0] KIND_KEY = 2'd1;
	localparam logic [1:0] KIND_TEXT = 2'd2;

	// datapath operations
	localparam int OPW = 3;
	localparam logic [OPW-1:0] OP_NONE = 3'd0;
	localparam logic [OPW-1:0] OP_CLEAR = 3'd1;
	localparam logic [OPW-1:0] OP_KEY = 3'd2;
	localparam logic [OPW-1:0] OP_BINIT = 3'd3;
	localparam logic [OPW-1:0] OP_BFILL = 3'd4;
	localparam logic [OPW-1:0] OP_LOOK = 3'd5;
	localparam logic [OPW-1:0] OP_OUT = 3'd6;

	// jump conditions
	localparam int JCW = 3;
	localparam logic [JCW-1:0] JC_ALWAYS = 3'd0;
	localparam logic [JCW-1:0] JC_ACCEPT = 3'd1;
	localparam logic [JCW-1:0] JC_DISPATCH = 3'd2;
	localparam logic [JCW-1:0] JC_LOOP = 3'd3;
	localparam logic [JCW-1:0] JC_OUTFREE = 3'd4;

	// microprogram steps
	localparam int STW = 3;
	localparam logic [STW-1:0] ST_FETCH = 3'd0;
	localparam logic [STW-1:0] ST_DISPATCH = 3'd1;
	localparam logic [STW-1:0] ST_CLEAR = 3'd2;
	localparam logic [STW-1:0] ST_KEY = 3'd3;
	localparam logic [STW-1:0] ST_BINIT = 3'd4;
	localparam logic [STW-1:0] ST_BFILL = 3'd5;
	localparam logic [STW-1:0] ST_LOOK = 3'd6;
	localparam logic [STW-1:0] ST_OUT = 3'd7;

	typedef struct packed {
		logic in_rdy;
		logic [OPW-1:0] op;
		logic [JCW-1:0] jc;
		logic [STW-1:0] target;
	} ucode_t;

	// sequencer to datapath
	typedef struct packed {
		logic in_rdy;
		logic [OPW-1:0] op;
	} kcs_ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic accept;
		logic [1:0] kind;
		logic tables_ready;
		logic fill_last;
		logic out_free;
	} kcs_stat_t;

	// microcode ROM
	function automatic ucode_t ucode(input logic [STW-1:0] step);
		ucode_t w;
		w = '{in_rdy: 1'b0, op: OP_NONE, jc: JC_ALWAYS, target: ST_FETCH};
		case (step)
			ST_FETCH: w = '{in_rdy: 1'b1, op: OP_NONE, jc: JC_ACCEPT, target: ST_DISPATCH};
			ST_DISPATCH: w = '{in_rdy: 1'b0, op: OP_NONE, jc: JC_DISPATCH, target: ST_FETCH};
			ST_CLEAR: w = '{in_rdy: 1'b0, op: OP_CLEAR, jc: JC_ALWAYS, target: ST_FETCH};
			ST_KEY: w = '{in_rdy: 1'b0, op: OP_KEY, jc: JC_ALWAYS, target: ST_FETCH};
			ST_BINIT: w = '{in_rdy: 1'b0, op: OP_BINIT, jc: JC_ALWAYS, target: ST_BFILL};
			ST_BFILL: w = '{in_rdy: 1'b0, op: OP_BFILL, jc: JC_LOOP, target: ST_LOOK};
			ST_LOOK: w = '{in_rdy: 1'b0, op: OP_LOOK, jc: JC_ALWAYS, target: ST_OUT};
			ST_OUT: w = '{in_rdy: 1'b0, op: OP_OUT, jc: JC_OUTFREE, target: ST_FETCH};
			default: w = '{in_rdy: 1'b0, op: OP_NONE, jc: JC_ALWAYS, target: ST_FETCH};
		endcase
		return w;
	endfunction

endpackage

[rtl/kcs_if.sv]
// Handshake channel interfaces: input items, result bytes, configuration.
interface kcs_item_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [7:0] value;
	modport source (output valid, output kind, output value, input ready);
	modport sink (input valid, input kind, input value, output ready);
endinterface

interface kcs_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	modport source (output valid, output out_byte, input ready);
	modport sink (input valid, input out_byte, output ready);
endinterface

interface kcs_cfg_if;
	logic valid;
	logic ready;
	logic decrypt_mode;
	modport source (output valid, output decrypt_mode, input ready);
	modport sink (input valid, input decrypt_mode, output ready);
endinterface

[rtl/kcs_seq.sv]
// Microcode sequencer: step counter, ROM fetch and conditional jumps.
module kcs_seq import kcs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input kcs_stat_t stat,
	output kcs_ctrl_t ctrl
);

	logic [STW-1:0] step_q;
	logic [STW-1:0] step_d;
	ucode_t word;

	assign word = ucode(step_q);
	assign ctrl = '{in_rdy: word.in_rdy, op: word.op};

	// next step
	always_comb begin
		step_d = word.target;
		case (word.jc)
			JC_ALWAYS: step_d = word.target;
			JC_ACCEPT: step_d = stat.accept ? word.target : step_q;
			JC_DISPATCH: begin
				case (stat.kind)
					KIND_CLEAR: step_d = ST_CLEAR;
					KIND_KEY: step_d = ST_KEY;
					KIND_TEXT: step_d = stat.tables_ready ? ST_LOOK : ST_BINIT;
					default: step_d = word.target;
				endcase
			end
			JC_LOOP: step_d = stat.fill_last ? word.target : step_q;
			JC_OUTFREE: step_d = stat.out_free ? word.target : step_q;
			default: step_d = word.target;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_FETCH;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

[rtl/kcs_dp.sv]
// Datapath: key state, alphabet and inverse memories, output register.
module kcs_dp import kcs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input kcs_ctrl_t ctrl,
	output kcs_stat_t stat,
	kcs_item_if.sink item,
	kcs_out_if.source result,
	kcs_cfg_if.sink cfg
);

	logic [1:0] kind_q;
	logic [7:0] value_q;
	logic decrypt_mode_q;
	logic [ALPHABET_SIZE-1:0] used_q;
	logic [CW-1:0] kc_q;
	logic ready_q;
	logic [CW-1:0] pos_q;
	logic [LW-1:0] l_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic [LW-1:0] sub_rd_q;
	logic [LW-1:0] inv_rd_q;
	logic [LW-1:0] sub_mem [ALPHABET_SIZE];
	logic [LW-1:0] inv_mem [ALPHABET_SIZE];

	logic accept;
	logic [8:0] diff;
	logic is_letter;
	logic [LW-1:0] idx;
	logic key_ok;
	logic fill_ok;
	logic fill_last;
	logic out_free;
	logic sub_we;
	logic inv_we;
	logic [LW-1:0] sub_wa;
	logic [LW-1:0] sub_wd;
	logic [LW-1:0] inv_wa;
	logic [LW-1:0] inv_wd;
	logic [LW-1:0] mapped;

	// handshakes
	assign item.ready = ctrl.in_rdy;
	assign accept = item.valid && ctrl.in_rdy;
	assign cfg.ready = 1'b1;
	assign out_free = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;
	assign result.out_byte = out_byte_q;

	// letter decode of the latched byte
	assign diff = {1'b0, value_q} - {1'b0, LETTER_A};
	assign is_letter = (value_q >= LETTER_A) && (diff < 9'(ALPHABET_SIZE));
	assign idx = diff[LW-1:0];

	assign key_ok = is_letter && !used_q[idx] && (kc_q < CW'(ALPHABET_SIZE));
	assign fill_ok = !used_q[l_q] && (pos_q < CW'(ALPHABET_SIZE));
	assign fill_last = (l_q == '0);

	assign stat = '{accept: accept, kind: kind_q, tables_ready: ready_q,
		fill_last: fill_last, out_free: out_free};

	// write port select: key append or fill
	always_comb begin
		sub_we = 1'b0;
		inv_we = 1'b0;
		sub_wa = kc_q[LW-1:0];
		sub_wd = idx;
		inv_wa = idx;
		inv_wd = kc_q[LW-1:0];
		if (ctrl.op == OP_KEY) begin
			sub_we = key_ok;
			inv_we = key_ok;
		end else if (ctrl.op == OP_BFILL) begin
			sub_we = fill_ok;
			inv_we = fill_ok;
			sub_wa = pos_q[LW-1:0];
			sub_wd = l_q;
			inv_wa = l_q;
			inv_wd = pos_q[LW-1:0];
		end
	end

	// substitution alphabet memory
	always_ff @(posedge clk) begin
		if (sub_we) begin
			sub_mem[sub_wa] <= sub_wd;
		end
		if (ctrl.op == OP_LOOK && is_letter) begin
			sub_rd_q <= sub_mem[idx];
		end
	end

	// inverse alphabet memory
	always_ff @(posedge clk) begin
		if (inv_we) begin
			inv_mem[inv_wa] <= inv_wd;
		end
		if (ctrl.op == OP_LOOK && is_letter) begin
			inv_rd_q <= inv_mem[idx];
		end
	end

	// input beat capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_CLEAR;
			value_q <= '0;
		end else if (accept) begin
			kind_q <= item.kind;
			value_q <= item.value;
		end
	end

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_mode_q <= 1'b0;
		end else if (cfg.valid) begin
			decrypt_mode_q <= cfg.decrypt_mode;
		end
	end

	// key state and fill counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			kc_q <= '0;
			ready_q <= 1'b0;
			pos_q <= '0;
			l_q <= '0;
		end else begin
			case (ctrl.op)
				OP_CLEAR: begin
					used_q <= '0;
					kc_q <= '0;
					ready_q <= 1'b0;
				end
				OP_KEY: begin
					if (key_ok) begin
						used_q[idx] <= 1'b1;
						kc_q <= kc_q + 1'b1;
						ready_q <= 1'b0;
					end
				end
				OP_BINIT: begin
					pos_q <= kc_q;
					l_q <= LW'(ALPHABET_SIZE - 1);
				end
				OP_BFILL: begin
					if (fill_ok) begin
						pos_q <= pos_q + 1'b1;
					end
					l_q <= l_q - 1'b1;
					if (fill_last) begin
						ready_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	assign mapped = decrypt_mode_q ? inv_rd_q : sub_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == OP_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_OUT && out_free) begin
			out_byte_q <= is_letter ? (LETTER_A + 8'(mapped)) : value_q;
		end
	end

endmodule

[rtl/keyword_substitution_cipher_top.sv]
// Clear and key beats pass the fetch, dispatch and their own step; a text beat passes
// fetch, dispatch, lookup and output steps to the result register. The first text beat
// after a key change adds a microcode loop of one fill step per letter, plus its setup step.
// One beat in flight at a time; the next beat is taken while a result waits in the output reg.
// Reset (arst_n low, async): empty key, tables not built, encrypt mode, no result pending.
`include "keyword_substitution_cipher_top_defines.svh"

// Top level: microcode sequencer driving the cipher datapath.
module keyword_substitution_cipher_top import kcs_pkg::*; (
	input logic clk,
	input logic arst_n,
	kcs_item_if.sink item,
	kcs_out_if.source result,
	kcs_cfg_if.sink cfg
);

	kcs_ctrl_t ctrl;
	kcs_stat_t stat;

	kcs_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.stat(stat),
		.ctrl(ctrl)
	);

	kcs_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.stat(stat),
		.item(item),
		.result(result),
		.cfg(cfg)
	);

	// sequencer leaves the fetch step right after taking a beat
	`KCS_ASSERT_NEXT(a_busy_after_beat, item.valid && item.ready, !item.ready)
	// a new result only comes from the output step
	`KCS_ASSERT_NOW(a_result_from_out, $rose(result.valid), $past(ctrl.op == OP_OUT))
	// last fill step marks the tables ready
	`KCS_ASSERT_NEXT(a_fill_done, ctrl.op == OP_BFILL && stat.fill_last, stat.tables_ready)

endmodule
